@@ sv/b64d_pkg.sv @@
// Shared types, constants and character classification for the base64 stream decoder.
package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int SEXT_W  = 6;
    localparam int POS_W   = 2;

    localparam logic [CHAR_W-1:0] ASCII_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] ASCII_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] ASCII_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] ASCII_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_DIG_0  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DIG_9  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] ASCII_SLASH  = 8'h2F;

    localparam logic [CHAR_W-1:0] LC_BASE    = 8'd26;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd52;
    localparam logic [SEXT_W-1:0] SEXT_PLUS  = 6'd62;
    localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

    typedef enum logic [1:0] {
        MODE_DECODING = 2'd0,
        MODE_PADDING  = 2'd1,
        MODE_TRAIL    = 2'd2,
        MODE_ERROR    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last;
    } item_t;

    // bit 6 set: not in the alphabet; bits 5:0: sextet value
    typedef struct packed {
        logic              bad;
        logic [SEXT_W-1:0] value;
    } sextet_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == ASCII_SPACE) || ((c >= ASCII_TAB) && (c <= ASCII_CR));
    endfunction

    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
        sextet_t           s;
        logic [CHAR_W-1:0] t;
        s = '{bad: 1'b0, value: '0};
        t = '0;
        priority if ((c >= ASCII_UC_A) && (c <= ASCII_UC_Z)) begin
            t       = c - ASCII_UC_A;
            s.value = t[SEXT_W-1:0];
        end else if ((c >= ASCII_LC_A) && (c <= ASCII_LC_Z)) begin
            t       = c - ASCII_LC_A + LC_BASE;
            s.value = t[SEXT_W-1:0];
        end else if ((c >= ASCII_DIG_0) && (c <= ASCII_DIG_9)) begin
            t       = c - ASCII_DIG_0 + DIGIT_BASE;
            s.value = t[SEXT_W-1:0];
        end else if (c == ASCII_PLUS) begin
            s.value = SEXT_PLUS;
        end else if (c == ASCII_SLASH) begin
            s.value = SEXT_SLASH;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

@@ sv/b64d_in_reg.sv @@
// Input register stage of the base64 stream decoder.
module b64d_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  b64d_pkg::item_t s_item,
    output logic            item_valid,
    output b64d_pkg::item_t item,
    input  logic            item_take
);
    import b64d_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ sv/b64d_core.sv @@
// Decode state, per-character decode logic and result register of the base64 stream decoder.
module b64d_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_valid,
    input  b64d_pkg::item_t item,
    output logic            item_take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import b64d_pkg::*;

    logic [POS_W-1:0]  group_pos_reg, group_pos_next;
    logic [SEXT_W-1:0] held_reg, held_next;
    mode_t             mode_reg, mode_next;

    logic              m_valid_reg;
    logic [CHAR_W-1:0] data_reg;
    logic              byte_valid_reg;
    logic              done_reg;
    logic              status_reg;

    logic              space;
    sextet_t           sx;
    logic              have_byte;
    logic [CHAR_W-1:0] byte_val;
    logic              status;
    logic              emit;
    logic              out_free;

    assign space    = is_space(item.char_in);
    assign sx       = sextet_of(item.char_in);
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = have_byte || item.last;
    assign item_take = item_valid && (out_free || !emit);

    always_comb begin
        group_pos_next = group_pos_reg;
        held_next      = held_reg;
        mode_next      = mode_reg;
        have_byte      = 1'b0;
        byte_val       = '0;
        unique case (mode_reg)
            MODE_DECODING: begin
                priority if (space) begin
                    mode_next = MODE_DECODING;
                end else if (!sx.bad) begin
                    unique case (group_pos_reg)
                        2'd0: begin
                            group_pos_next = 2'd1;
                        end
                        2'd1: begin
                            byte_val       = {held_reg, sx.value[5:4]};
                            have_byte      = 1'b1;
                            group_pos_next = 2'd2;
                        end
                        2'd2: begin
                            byte_val       = {held_reg[3:0], sx.value[5:2]};
                            have_byte      = 1'b1;
                            group_pos_next = 2'd3;
                        end
                        default: begin
                            byte_val       = {held_reg[1:0], sx.value};
                            have_byte      = 1'b1;
                            group_pos_next = 2'd0;
                        end
                    endcase
                    held_next = sx.value;
                end else if ((item.char_in == ASCII_EQUALS) && group_pos_reg[1]) begin
                    mode_next = MODE_PADDING;
                end else begin
                    mode_next = MODE_ERROR;
                end
            end
            MODE_PADDING: begin
                priority if (space) begin
                    mode_next = MODE_TRAIL;
                end else if (item.char_in != ASCII_EQUALS) begin
                    mode_next = MODE_ERROR;
                end
            end
            MODE_TRAIL: begin
                if (!space) begin
                    mode_next = MODE_ERROR;
                end
            end
            default: begin
                mode_next = MODE_ERROR;
            end
        endcase
        status = item.last && ((mode_next == MODE_ERROR) ||
                 ((mode_next == MODE_DECODING) && (group_pos_next == 2'd1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_pos_reg <= '0;
            held_reg      <= '0;
            mode_reg      <= MODE_DECODING;
            m_valid_reg   <= 1'b0;
        end else begin
            if (item_take) begin
                if (item.last) begin
                    group_pos_reg <= '0;
                    held_reg      <= '0;
                    mode_reg      <= MODE_DECODING;
                end else begin
                    group_pos_reg <= group_pos_next;
                    held_reg      <= held_next;
                    mode_reg      <= mode_next;
                end
            end
            if (item_take && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            data_reg       <= byte_val;
            byte_valid_reg <= have_byte;
            done_reg       <= item.last;
            status_reg     <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {status_reg, byte_valid_reg};
    assign m_tlast  = done_reg;

`ifndef SYNTHESIS
    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg) |-> done_reg)
        else $error("status raised on a word that does not end the message");

    a_no_data_without_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !byte_valid_reg) |-> (data_reg == '0))
        else $error("data byte not zero on a word without a byte");

    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item.last) |=>
        ((group_pos_reg == '0) && (mode_reg == MODE_DECODING)))
        else $error("state not returned to start after final character");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == MODE_ERROR) && !(item_take && item.last)) |=>
        (mode_reg == MODE_ERROR))
        else $error("error mode left before end of message");

    a_pos_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg != MODE_DECODING) && !(item_take && item.last)) |=>
        $stable(group_pos_reg))
        else $error("group position moved outside decoding mode");
`endif

endmodule

@@ sv/lenient_base64_stream_decoder_top.sv @@
// Top level of the lenient base64 stream decoder.
//
// Input channel s_*: one character per word in s_tdata, s_tlast on the
// final character of a message. Result channel m_*: one word per decoded
// byte and one on the final character (both may share a word).
// m_tuser[0] flags a valid byte in m_tdata, m_tlast ends the message and
// m_tuser[1] then reports an illegal sequence. Characters that produce
// neither byte nor end of message give no result word.
// A character is accepted into the input register and its result word
// is then loaded into the result register. Throughput: one character
// per cycle while the result register can take a word, set by the
// single decode step between the two registers. A character with no
// result is still taken while the result register is held.
// Reset: the decode state returns to the start of a message and both
// registers empty. When the receiver stalls, the result word holds, one
// more character waits in the input register, and s_tready falls.
module lenient_base64_stream_decoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] status
    output logic       m_tlast
);
    import b64d_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  item_take;

    assign s_item = '{char_in: s_tdata, last: s_tlast};

    b64d_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    b64d_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the lenient base64 stream decoder: directed, back-pressure and random messages.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 30;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       done;
        logic       status;
    } result_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_in
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] data_byte
    logic [1:0] m_tuser;            // [0] byte_valid, [1] status
    logic       m_tlast;

    lenient_base64_stream_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // decoder state as predicted
    mode_t       dec_mode = MODE_DECODING;
    logic [1:0]  dec_pos  = 2'd0;
    logic [5:0]  dec_held = 6'd0;

    result_word_t pending_words[$];
    logic [7:0]   text_buf[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int msgs_sent      = 0;
    int words_checked  = 0;
    int bytes_checked  = 0;
    int illegal_ends   = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit sender_steady  = 1'b0;

    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int stall_mode   = 0;
    int mode_left    = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_words.size());
            $display("lenient_base64_stream_decoder_top verification failed");
            $finish;
        end
    end

    // receiver: own stall pattern plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    function automatic int char_sextet(input logic [7:0] c);
        if (c >= ASCII_UC_A && c <= ASCII_UC_Z) return int'(c - ASCII_UC_A);
        if (c >= ASCII_LC_A && c <= ASCII_LC_Z) return int'(c - ASCII_LC_A) + int'(LC_BASE);
        if (c >= ASCII_DIG_0 && c <= ASCII_DIG_9) return int'(c - ASCII_DIG_0) + int'(DIGIT_BASE);
        if (c == ASCII_PLUS) return int'(SEXT_PLUS);
        if (c == ASCII_SLASH) return int'(SEXT_SLASH);
        return -1;
    endfunction

    function automatic logic char_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [7:0] sextet_char(input int v);
        if (v < 26) return 8'(ASCII_UC_A + v);
        if (v < 52) return 8'(ASCII_LC_A + v - 26);
        if (v < 62) return 8'(ASCII_DIG_0 + v - 52);
        if (v == 62) return ASCII_PLUS;
        return ASCII_SLASH;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0a;
            3: return 8'h0b;
            4: return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    task decode_char(input logic [7:0] c, input logic l,
                     output logic produced, output result_word_t w);
        int         sv;
        logic [5:0] v;
        logic       blank;
        blank = char_blank(c);
        sv    = char_sextet(c);
        v     = 6'(sv);
        w     = '0;
        case (dec_mode)
            MODE_DECODING: begin
                if (blank) begin
                    // skip
                end else if (sv >= 0) begin
                    case (dec_pos)
                        2'd0: begin
                            dec_pos = 2'd1;
                        end
                        2'd1: begin
                            w.byte_valid = 1'b1;
                            w.data_byte  = {dec_held, v[5:4]};
                            dec_pos      = 2'd2;
                        end
                        2'd2: begin
                            w.byte_valid = 1'b1;
                            w.data_byte  = {dec_held[3:0], v[5:2]};
                            dec_pos      = 2'd3;
                        end
                        default: begin
                            w.byte_valid = 1'b1;
                            w.data_byte  = {dec_held[1:0], v};
                            dec_pos      = 2'd0;
                        end
                    endcase
                    dec_held = v;
                end else if (c == ASCII_EQUALS && dec_pos >= 2'd2) begin
                    dec_mode = MODE_PADDING;
                end else begin
                    dec_mode = MODE_ERROR;
                end
            end
            MODE_PADDING: begin
                if (blank) dec_mode = MODE_TRAIL;
                else if (c != ASCII_EQUALS) dec_mode = MODE_ERROR;
            end
            MODE_TRAIL: begin
                if (!blank) dec_mode = MODE_ERROR;
            end
            default: begin
            end
        endcase
        if (l) begin
            w.done   = 1'b1;
            w.status = (dec_mode == MODE_ERROR) ||
                       (dec_mode == MODE_DECODING && dec_pos == 2'd1);
            dec_mode = MODE_DECODING;
            dec_pos  = 2'd0;
            dec_held = 6'd0;
        end
        produced = w.byte_valid || l;
    endtask

    task report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        result_word_t new_w;
        result_word_t exp_w;
        logic         produced;
        if (aresetn && s_tvalid && s_tready) begin
            decode_char(s_tdata, s_tlast, produced, new_w);
            if (produced) pending_words.push_back(new_w);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%02h user=%b last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                exp_w = pending_words.pop_front();
                if (m_tuser[0] !== exp_w.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b",
                                              m_tuser[0], exp_w.byte_valid));
                if (m_tdata !== exp_w.data_byte)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              m_tdata, exp_w.data_byte));
                if (m_tlast !== exp_w.done)
                    report_mismatch($sformatf("done %b, want %b", m_tlast, exp_w.done));
                if (m_tuser[1] !== exp_w.status)
                    report_mismatch($sformatf("status %b, want %b",
                                              m_tuser[1], exp_w.status));
                words_checked++;
                if (exp_w.byte_valid) bytes_checked++;
                if (exp_w.done && exp_w.status) illegal_ends++;
            end
        end
    end

    task send_char(input logic [7:0] c, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_steady ? 0 :
                  (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        msgs_sent++;
    endtask

    task send_text(input string s);
        text_buf = {};
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_buffer();
    endtask

    task push_data_char();
        if ($urandom_range(0, 7) == 0) text_buf.push_back(blank_char());
        text_buf.push_back(sextet_char($urandom_range(0, 63)));
    endtask

    task build_clean_message();
        int ngroups;
        int tail;
        int pad;
        text_buf = {};
        ngroups = $urandom_range(0, 5);
        for (int g = 0; g < ngroups * 4; g++) push_data_char();
        tail = $urandom_range(0, 3);
        for (int k = 0; k < tail; k++) push_data_char();
        pad = 0;
        if (tail == 2) pad = $urandom_range(0, 3);
        else if (tail == 3) pad = $urandom_range(0, 1);
        repeat (pad) text_buf.push_back(ASCII_EQUALS);
        repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
        if (text_buf.size() == 0) text_buf.push_back(blank_char());
    endtask

    task test_directed();
        send_text("/w==");
        send_text("AAA=\n");
        send_text("A");
        send_text(" ");
        send_text("=");
        text_buf = {8'h00, 8'hff};
        send_buffer();
        send_text("z9= =");
        text_buf = {ASCII_PLUS, 8'h09, 8'h0b, 8'h0c, 8'h0d, ASCII_PLUS};
        send_buffer();
    endtask

    task test_backpressure();
        sender_steady = 1'b1;
        burst_left    = 0;
        hold_req_cnt++;
        for (int m = 0; m < 4; m++) begin
            text_buf = {};
            for (int k = 0; k < 16; k++) text_buf.push_back(sextet_char($urandom_range(0, 63)));
            send_buffer();
        end
        sender_steady = 1'b0;
    endtask

    task test_random();
        int kind;
        int pos;
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                build_clean_message();
            end else if (kind < 18) begin
                build_clean_message();
                pos = $urandom_range(0, text_buf.size() - 1);
                if ($urandom_range(0, 1) == 0) text_buf[pos] = 8'($urandom_range(0, 255));
                else text_buf.insert(pos, ASCII_EQUALS);
            end else begin
                text_buf = {};
                repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_buffer();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d messages, %0d characters under random stalls and one long hold-off.",
                 msgs_sent, items_sent);
        $display("Checked %0d result words: %0d bytes, %0d illegal endings, %0d mismatches.",
                 words_checked, bytes_checked, illegal_ends, mismatch_count);
        if (mismatch_count == 0) begin
            $display("lenient_base64_stream_decoder_top verification clean");
        end else begin
            $display("lenient_base64_stream_decoder_top verification failed");
        end
        $finish;
    end

endmodule
